// ===== src/cdq_pkg.sv =====
// Shared constants, command and status codes, and the result record of the
// circular deque with search. Used by the channel interfaces, the top module and the sequencer.
package cdq_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int CMD_W      = 3;
    localparam int IN_VALUE_W = 32;
    localparam int STATUS_W   = 2;
    localparam int FIELD_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [FIELD_W-1:0]   position;
        logic [FIELD_W-1:0]   count;
    } result_t;

endpackage

// ===== src/cdq_req_if.sv =====
// Command channel of the circular deque: valid/ready handshake with the
// command code and the value. Depends on cdq_pkg.
interface cdq_req_if;
    import cdq_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             cmd;
    logic signed [IN_VALUE_W-1:0] value;

    modport source (output valid, cmd, value, input ready);
    modport sink   (input valid, cmd, value, output ready);
endinterface

// ===== src/cdq_rsp_if.sv =====
// Result channel of the circular deque: valid/ready handshake with status,
// position and count. Depends on cdq_pkg.
interface cdq_rsp_if;
    import cdq_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  position;
    logic [FIELD_W-1:0]  count;

    modport source (output valid, status, position, count, input ready);
    modport sink   (input valid, status, position, count, output ready);
endinterface

// ===== src/circular_deque_with_search.sv =====
// A bounded double-ended queue of DEPTH signed values kept as a ring in one
// synchronous memory. A command is taken only while the sequencer is idle; inserts,
// removals and the unused codes pass their result from the sequencer's result register
// to the output register; a search first reads the stored entries one by one through
// the single memory read port, walking the ring from the front until a match or the end.
// A finished result sits in an output register and does not hold up the next command.
// The memory needs no clearing after reset. Depends on cdq_pkg, cdq_req_if, cdq_rsp_if,
// cdq_ctrl and cdq_ram.
module circular_deque_with_search #(
    parameter int DEPTH       = cdq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = cdq_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    cdq_req_if.sink  req,
    cdq_rsp_if.source rsp
);
    import cdq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_WIDTH-1:0] key;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   res_valid;
    result_t                res;
    logic                   res_ready;

    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg,       out_next;

    generate
        if (VALUE_WIDTH <= IN_VALUE_W)
        begin : g_trunc
            assign key = req.value[VALUE_WIDTH-1:0];
        end
        else
        begin : g_sext
            assign key = {{(VALUE_WIDTH - IN_VALUE_W){req.value[IN_VALUE_W-1]}}, req.value};
        end
    endgenerate

    cdq_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .key       (key),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    cdq_ram #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_reg.status;
    assign rsp.position = out_reg.position;
    assign rsp.count    = out_reg.count;
endmodule

// ===== src/cdq_ram.sv =====
// Entry store of the circular deque: one write port and one read port with
// a registered read. Depends on nothing.
module cdq_ram #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [VALUE_WIDTH-1:0] rd_data
);
    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== src/cdq_ctrl.sv =====
// Sequencer of the circular deque: keeps the front index and the count,
// issues the memory writes of inserts and walks the ring for a search.
// Depends on cdq_pkg, cdq_req_if and the entry store's ports.
module cdq_ctrl #(
    parameter int DEPTH       = cdq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = cdq_pkg::VALUE_WIDTH_DEFAULT,
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    cdq_req_if.sink                req,
    input  logic [VALUE_WIDTH-1:0] key,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output logic [VALUE_WIDTH-1:0] wr_data,
    output logic                   rd_en,
    output logic [IDX_W-1:0]       rd_addr,
    input  logic [VALUE_WIDTH-1:0] rd_data,
    output logic                   res_valid,
    output cdq_pkg::result_t       res,
    input  logic                   res_ready
);
    import cdq_pkg::*;

    localparam int SUM_W = IDX_W + 1;

    typedef enum logic [1:0] {
        IDLE,
        SEARCH,
        HOLD
    } state_t;

    state_t                 state_reg,  state_next;
    logic [IDX_W-1:0]       front_reg,  front_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [IDX_W-1:0]       ptr_reg,    ptr_next;
    logic [IDX_W-1:0]       idx_reg,    idx_next;
    logic [VALUE_WIDTH-1:0] key_reg,    key_next;
    result_t                res_reg,    res_next;

    logic                   full;
    logic                   empty;
    logic [IDX_W-1:0]       front_inc;
    logic [IDX_W-1:0]       front_dec;
    logic [IDX_W-1:0]       ptr_inc;
    logic [SUM_W-1:0]       back_sum;
    logic [IDX_W-1:0]       back_addr;
    logic [CNT_W-1:0]       idx_plus;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign ptr_inc   = (ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_addr = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(back_sum);
    assign idx_plus  = CNT_W'(idx_reg) + CNT_W'(1);

    assign req.ready = (state_reg == IDLE);
    assign res_valid = (state_reg == HOLD);
    assign res       = res_reg;
    assign wr_data   = key;

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = front_dec;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;

        case (state_reg)
            IDLE:
            begin
                if (req.valid)
                begin
                    state_next        = HOLD;
                    res_next.status   = ST_OK;
                    res_next.position = '0;
                    case (req.cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (req.cmd == CMD_PUSH_FRONT || empty)
                                begin
                                    wr_addr    = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    wr_addr = back_addr;
                                end
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                front_next = (count_reg == CNT_W'(1)) ? '0 : front_inc;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                if (count_reg == CNT_W'(1))
                                begin
                                    front_next = '0;
                                end
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (empty)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                ptr_next   = front_inc;
                                idx_next   = '0;
                                key_next   = key;
                                state_next = SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.count = FIELD_W'(count_next);
                end
            end
            SEARCH:
            begin
                rd_en    = 1'b1;
                rd_addr  = ptr_reg;
                ptr_next = ptr_inc;
                idx_next = IDX_W'(idx_plus);
                res_next.count = FIELD_W'(count_reg);
                if (rd_data == key_reg)
                begin
                    res_next.status   = ST_OK;
                    res_next.position = FIELD_W'(idx_plus);
                    state_next        = HOLD;
                end
                else if (idx_plus == count_reg)
                begin
                    res_next.status   = ST_NOT_FOUND;
                    res_next.position = '0;
                    state_next        = HOLD;
                end
            end
            HOLD:
            begin
                if (res_ready)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count exceeds the store depth");

    a_empty_front_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (front_reg == '0))
        else $error("empty store with a nonzero front index");

    a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEARCH) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("search walked past the stored elements");

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == IDLE && req.valid))
        else $error("memory write outside a command transaction");

    a_search_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEARCH) |=> ($stable(count_reg) && $stable(front_reg)))
        else $error("search changed the ring pointers");
endmodule
